// File: rtl/dsti_pkg.sv
package dsti_pkg;

  localparam int unsigned ACC_W     = 37;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // longest accepted string, counting the sign
  localparam logic [POS_W-1:0] MAX_CHARS = 8'd11;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] LIM_S32 = 37'd2147483647;
  localparam logic [ACC_W-1:0] LIM_S16 = 37'd32767;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LZ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;

  typedef enum logic {
    TGT_S32 = 1'b0,
    TGT_S16 = 1'b1
  } target_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_ZPEEK  = 3'd2,
    PH_ZEROS  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] convert_limit;
    logic               ignore_lz;
    target_t            target;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic                      ok;
  } result_t;

endpackage

// File: rtl/dsti_cfg_regs.sv
module dsti_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dsti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsti_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output dsti_pkg::cfg_t                     cfg
);

  dsti_pkg::cfg_t cfg_r;
  dsti_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        dsti_pkg::REG_CONVERT_LIMIT: cfg_nxt.convert_limit = cfg_wdata;
        dsti_pkg::REG_IGNORE_LZ:     cfg_nxt.ignore_lz = cfg_wdata[0];
        dsti_pkg::REG_TARGET_WIDTH:  cfg_nxt.target = dsti_pkg::target_t'(cfg_wdata[0]);
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{convert_limit: '0, ignore_lz: 1'b0, target: dsti_pkg::TGT_S32};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/dsti_step.sv
module dsti_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsti_pkg::cfg_t                  cfg,
  input  logic                            fire,
  input  logic [dsti_pkg::CHAR_W-1:0]     char_code,
  output dsti_pkg::result_t               res
);

  dsti_pkg::phase_t                phase_r, phase_nxt;
  logic [dsti_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [dsti_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic                            neg_r, neg_nxt;

  logic [dsti_pkg::CHAR_W-1:0]     diff;
  logic [3:0]                      dig;
  logic                            is_dig;
  logic                            is_nul;
  logic [dsti_pkg::ACC_W+3:0]      wide;
  logic [dsti_pkg::POS_W-1:0]      pos_inc;
  logic                            first_path;
  logic                            zeros_path;
  logic                            take_digit;
  logic [dsti_pkg::ACC_W-1:0]      digit_acc;
  logic                            fin;
  logic                            fail;
  logic                            zero_ok;
  logic                            emit;
  logic                            limit_hit;
  logic [dsti_pkg::ACC_W-1:0]      lim;
  logic                            over;
  logic                            good;
  logic [dsti_pkg::VALUE_W-1:0]    mag;
  logic [dsti_pkg::VALUE_W-1:0]    sgn;

  assign diff   = char_code - dsti_pkg::CHAR_ZERO;
  assign dig    = diff[3:0];
  assign is_dig = (char_code >= dsti_pkg::CHAR_ZERO) && (char_code <= dsti_pkg::CHAR_NINE);
  assign is_nul = (char_code == dsti_pkg::CHAR_NUL);

  // acc * 10 + digit as two shifted adds
  assign wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
              + {{(dsti_pkg::ACC_W){1'b0}}, dig};

  assign pos_inc = (pos_r == {dsti_pkg::POS_W{1'b1}}) ? pos_r : pos_r + 1'b1;

  assign limit_hit = (cfg.convert_limit != '0) &&
                     (({1'b0, pos_r} + 9'd1) >= {1'b0, cfg.convert_limit});

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    first_path = 1'b0;
    zeros_path = 1'b0;
    take_digit = 1'b0;
    digit_acc  = {{(dsti_pkg::ACC_W-4){1'b0}}, dig};
    fin        = 1'b0;
    fail       = 1'b0;
    zero_ok    = 1'b0;

    case (phase_r)
      dsti_pkg::PH_START: begin
        if (char_code == dsti_pkg::CHAR_MINUS) begin
          neg_nxt   = 1'b1;
          pos_nxt   = 8'd1;
          phase_nxt = dsti_pkg::PH_FIRST;
        end else begin
          first_path = 1'b1;
        end
      end
      dsti_pkg::PH_FIRST: first_path = 1'b1;
      dsti_pkg::PH_ZPEEK: begin
        if (is_nul)             zero_ok = 1'b1;
        else if (!cfg.ignore_lz) fail = 1'b1;
        else                    zeros_path = 1'b1;
      end
      dsti_pkg::PH_ZEROS: zeros_path = 1'b1;
      dsti_pkg::PH_DIGITS: begin
        if (is_nul)                          fin = 1'b1;
        else if (pos_r >= dsti_pkg::MAX_CHARS) fail = 1'b1;
        else if (!is_dig)                    fail = 1'b1;
        else begin
          take_digit = 1'b1;
          digit_acc  = (|wide[dsti_pkg::ACC_W+3:dsti_pkg::ACC_W]) ?
                       dsti_pkg::ACC_MAX : wide[dsti_pkg::ACC_W-1:0];
        end
      end
      dsti_pkg::PH_DRAIN: begin
        if (is_nul) begin
          phase_nxt = dsti_pkg::PH_START;
          pos_nxt   = '0;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
        end
      end
      default: begin
        phase_nxt = dsti_pkg::PH_START;
        pos_nxt   = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
      end
    endcase

    // first character of the magnitude
    if (first_path) begin
      if (is_nul) fail = 1'b1;
      else if (char_code == dsti_pkg::CHAR_ZERO) begin
        if (cfg.convert_limit == 8'd1) zero_ok = 1'b1;
        else begin
          pos_nxt   = pos_inc;
          phase_nxt = dsti_pkg::PH_ZPEEK;
        end
      end else if (!is_dig) fail = 1'b1;
      else take_digit = 1'b1;
    end

    // run of leading zeros being skipped
    if (zeros_path) begin
      if (pos_r >= dsti_pkg::MAX_CHARS) fail = 1'b1;
      else if (char_code == dsti_pkg::CHAR_ZERO) begin
        pos_nxt   = pos_inc;
        phase_nxt = dsti_pkg::PH_ZEROS;
      end else if (is_nul) zero_ok = 1'b1;
      else if (!is_dig)   fail = 1'b1;
      else                take_digit = 1'b1;
    end

    if (take_digit) begin
      acc_nxt = digit_acc;
      if (limit_hit) fin = 1'b1;
      else begin
        pos_nxt   = pos_inc;
        phase_nxt = dsti_pkg::PH_DIGITS;
      end
    end

    // range check on the finished magnitude
    lim  = (cfg.target == dsti_pkg::TGT_S16) ? dsti_pkg::LIM_S16 : dsti_pkg::LIM_S32;
    lim  = lim + {{(dsti_pkg::ACC_W-1){1'b0}}, neg_r};
    over = acc_nxt > lim;
    good = (fin && !over) || zero_ok;
    mag  = fin ? acc_nxt[dsti_pkg::VALUE_W-1:0] : '0;
    sgn  = neg_r ? ({dsti_pkg::VALUE_W{1'b0}} - mag) : mag;

    emit = fin || fail || zero_ok;
    if (emit) begin
      if (is_nul) begin
        phase_nxt = dsti_pkg::PH_START;
        pos_nxt   = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
      end else begin
        phase_nxt = dsti_pkg::PH_DRAIN;
      end
    end

    res.valid = emit;
    res.ok    = good;
    res.value = good ? sgn : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dsti_pkg::PH_START;
      pos_r   <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

// File: rtl/dsti_out_reg.sv
module dsti_out_reg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  dsti_pkg::result_t                     res,
  input  logic                                  out_stall,
  output logic                                  free,
  output logic                                  out_valid,
  output logic signed [dsti_pkg::VALUE_W-1:0]   out_value,
  output logic                                  out_ok
);

  logic                                valid_r, valid_nxt;
  logic signed [dsti_pkg::VALUE_W-1:0] value_r;
  logic                                ok_r;

  // slot is free when empty or being taken this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= res.value;
      ok_r    <= res.ok;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_ok    = ok_r;

endmodule

// File: rtl/decimal_string_to_int_unit.sv
// channel   | ports                               | direction
// ----------+-------------------------------------+--------------------------------
// input     | in_valid in_stall in_char_code      | one string byte per transaction
// result    | out_valid out_stall out_value out_ok| at most one per string
// config    | cfg_we cfg_index cfg_wdata          | register writes, no read-back
//
// one byte per cycle sustained while no result waits on a stalled output; a byte is held in
// the input register and decoded against the string state in the cycle after it is accepted,
// and its result (if any) is loaded into the output register once that register is free,
// so out_valid follows the terminating or deciding byte through both registers
// reset (synchronous, active low) clears config, string state and both valids
// a waiting result stalls the input only when the byte in the input register
// would produce another result
module decimal_string_to_int_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dsti_pkg::CHAR_W-1:0]           in_char_code,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dsti_pkg::VALUE_W-1:0]   out_value,
  output logic                                  out_ok,
  // configuration port
  input  logic                                  cfg_we,
  input  logic [dsti_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dsti_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  dsti_pkg::cfg_t              cfg;
  dsti_pkg::result_t           res;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [dsti_pkg::CHAR_W-1:0] s1_char_r;
  logic                        s1_fire;
  logic                        out_free;
  logic                        in_take;

  dsti_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // string state machine, advances whenever the held byte can retire
  dsti_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (s1_fire),
    .char_code (s1_char_r),
    .res       (res)
  );

  // a byte that yields no result never waits on the output side
  assign s1_fire  = s1_valid_r && (!res.valid || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_fire;
    if (in_take) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // byte register, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
    end
  end

  dsti_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && res.valid),
    .res       (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_ok    (out_ok)
  );

endmodule

// File: rtl/dsti_checker.sv
module dsti_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dsti_pkg::VALUE_W-1:0] out_value,
  input logic                                out_ok
);

  // reset empties both sides
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall left set after reset");

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side can move");

  // failed conversion carries zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0)
    else $error("failed result with nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_ok))
    else $error("stalled result changed");

endmodule

bind decimal_string_to_int_unit dsti_checker u_dsti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value),
  .out_ok    (out_ok)
);
